>>> hdl/llr_pkg.sv
// Shared types and constants for the logarithmic luma remap block.
package llr_pkg;

	localparam int LEVELS      = 256;
	localparam int LEVEL_MAX   = LEVELS - 1;
	localparam int DIV_STEPS   = 24;
	localparam int SQR_STEPS   = 16;
	localparam int CNT_W       = 5;

	localparam logic [11:0] CONTRAST_RESET = 12'd256;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_OBSERVE = 2'd1,
		ACT_MAP     = 2'd2
	} llr_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YLD,
		ST_NORM,
		ST_SQR,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} llr_state_t;

	typedef struct packed {
		logic load;
		logic zero_res;
		logic div_step;
		logic y_load;
		logic norm_step;
		logic sqr_step;
		logic mul1;
		logic mul2;
	} llr_ctl_t;

endpackage

>>> hdl/log_luminance_remap.sv
// Map items: e = 0..8 normalizing shifts lie between the divide and the squaring steps.
// Divider (24 steps), shifter and squaring multiplier (16 steps) share one datapath.
// A new beat is taken in the cycle after the result moves to the output register.
// Clear, observe and unused actions leave the sequencer idle; a map with zero peak goes straight to done.
// Reset (arst_n low) clears peak to 0, contrast to 1.0 and drops any pending beat.
module log_luminance_remap
	import llr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data,      // contrast_gain
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,     // pixel_value
	input  logic [1:0]  s_axis_tuser,     // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata      // mapped_value
);

	logic [11:0] contrast_q;
	logic [7:0]  peak_q;
	logic        out_valid_q;
	logic [7:0]  out_data_q;

	logic        in_fire;
	logic        out_free;
	logic        out_load;
	logic        norm_done;
	logic [7:0]  result;
	llr_ctl_t    ctl;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q  <= CONTRAST_RESET;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				contrast_q <= cfg_wr_data;
			end
			if (in_fire) begin
				case (s_axis_tuser)
					ACT_CLEAR:   peak_q <= '0;
					ACT_OBSERVE: begin
						if (s_axis_tdata > peak_q) begin
							peak_q <= s_axis_tdata;
						end
					end
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

	llr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.action    (s_axis_tuser),
		.peak_zero (peak_q == 8'd0),
		.norm_done (norm_done),
		.out_free  (out_free),
		.ready     (s_axis_tready),
		.out_load  (out_load),
		.ctl       (ctl)
	);

	llr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.pixel     (s_axis_tdata),
		.peak      (peak_q),
		.contrast  (contrast_q),
		.norm_done (norm_done),
		.result    (result)
	);

	a_peak_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_axis_tuser == ACT_OBSERVE |=> peak_q >= $past(s_axis_tdata))
		else $error("observed sample above peak");

	a_peak_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_axis_tuser == ACT_CLEAR |=> peak_q == 8'd0)
		else $error("peak not cleared");

	a_zero_peak_map: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_axis_tuser == ACT_MAP && peak_q == 8'd0 && !m_axis_tvalid
		|-> ##2 m_axis_tvalid && m_axis_tdata == 8'd0)
		else $error("map with zero peak did not give zero");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("result overwrote a pending beat");

endmodule

>>> hdl/llr_seq.sv
// Sequencer that steps the shared datapath through divide, normalize, log and scale.
module llr_seq
	import llr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [1:0] action,
	input  logic       peak_zero,
	input  logic       norm_done,
	input  logic       out_free,
	output logic       ready,
	output logic       out_load,
	output llr_ctl_t   ctl
);

	llr_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              map_fire;

	assign map_fire = in_fire && (action == ACT_MAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV || state_q == ST_SQR) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (map_fire) begin
					state_d = peak_zero ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_YLD;
				end
			end
			ST_YLD:  state_d = ST_NORM;
			ST_NORM: begin
				if (norm_done) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				if (cnt_q == CNT_W'(SQR_STEPS - 1)) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready         = (state_q == ST_IDLE);
		out_load      = (state_q == ST_DONE) && out_free;
		ctl.load      = (state_q == ST_IDLE) && map_fire;
		ctl.zero_res  = (state_q == ST_IDLE) && map_fire && peak_zero;
		ctl.div_step  = (state_q == ST_DIV);
		ctl.y_load    = (state_q == ST_YLD);
		ctl.norm_step = (state_q == ST_NORM) && !norm_done;
		ctl.sqr_step  = (state_q == ST_SQR);
		ctl.mul1      = (state_q == ST_MUL1);
		ctl.mul2      = (state_q == ST_MUL2);
	end

	a_cnt_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("divide step count overran");

	a_norm_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NORM && state_d == ST_SQR |-> norm_done)
		else $error("log started on unnormalized mantissa");

endmodule

>>> hdl/llr_dp.sv
// Datapath with one shared multiplier, restoring divider step and shift register.
module llr_dp
	import llr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  llr_ctl_t    ctl,
	input  logic [7:0]  pixel,
	input  logic [7:0]  peak,
	input  logic [11:0] contrast,
	output logic        norm_done,
	output logic [7:0]  result
);

	logic [24:0] acc_q;
	logic [7:0]  rem_q;
	logic [3:0]  exp_q;
	logic [15:0] frac_q;
	logic [31:0] prod_q;
	logic [7:0]  res_q;

	logic [8:0]  shifted;
	logic [9:0]  diff;
	logic [19:0] mul_a;
	logic [16:0] mul_b;
	logic [36:0] prod;
	logic [17:0] sq_t;
	logic [39:0] scaled;

	assign shifted   = {rem_q, acc_q[23]};
	assign diff      = {1'b0, shifted} - {2'b0, peak};
	assign norm_done = (acc_q[24:17] == 8'd0);
	assign sq_t      = prod[33:16];
	assign scaled    = {8'd0, prod_q} * 40'(LEVEL_MAX);
	assign result    = res_q;

	always_comb begin
		if (ctl.mul1) begin
			mul_a = {exp_q, frac_q};
			mul_b = {5'd0, contrast};
		end else begin
			mul_a = {3'd0, acc_q[16:0]};
			mul_b = acc_q[16:0];
		end
		prod = 37'(mul_a) * 37'(mul_b);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q  <= {1'b0, pixel, 16'd0};
			rem_q  <= '0;
			exp_q  <= '0;
			frac_q <= '0;
		end
		if (ctl.div_step) begin
			if (!diff[9]) begin
				rem_q <= diff[7:0];
				acc_q <= {acc_q[24], acc_q[22:0], 1'b1};
			end else begin
				rem_q <= shifted[7:0];
				acc_q <= {acc_q[24], acc_q[22:0], 1'b0};
			end
		end
		if (ctl.y_load) begin
			acc_q <= {1'b0, acc_q[23:0]} + 25'(1 << 16);
		end
		if (ctl.norm_step) begin
			acc_q <= acc_q >> 1;
			exp_q <= exp_q + 4'd1;
		end
		if (ctl.sqr_step) begin
			if (sq_t[17]) begin
				acc_q  <= {8'd0, sq_t[17:1]};
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				acc_q  <= {8'd0, sq_t[16:0]};
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
		if (ctl.mul1) begin
			prod_q <= prod[31:0];
		end
		if (ctl.zero_res) begin
			res_q <= '0;
		end else if (ctl.mul2) begin
			if (scaled[39:24] >= 16'(LEVELS)) begin
				res_q <= 8'(LEVEL_MAX);
			end else begin
				res_q <= scaled[31:24];
			end
		end
	end

	a_rem_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> rem_q < peak)
		else $error("divider remainder not below divisor");

	a_mant_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sqr_step |-> acc_q[24:17] == 8'd0)
		else $error("mantissa reached 2.0 before squaring");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the logarithmic luma remap block.
module testbench;
	import llr_pkg::*;

	localparam logic [1:0] ACT_UNUSED    = 2'd3;
	localparam int         SETTLE_CYCLES = 64;
	localparam int         BEATS_PER_SET = 250;
	localparam int         GAIN_SETTINGS = 8;
	localparam longint     RUN_LIMIT     = 15_000_000;

	class remap_tracker;
		logic [7:0]  peak_level;
		logic [11:0] contrast;
		logic [7:0]  expected_levels[$];
		int unsigned mismatches;

		function new();
			peak_level = '0;
			contrast   = CONTRAST_RESET;
			mismatches = 0;
		endfunction

		function logic [63:0] log2_fixed(logic [63:0] y);
			logic [63:0] shift;
			logic [63:0] m;
			logic [63:0] frac;
			shift = 0;
			frac  = 0;
			while (shift < 40 && (y >> (17 + shift)) != 0)
				shift++;
			m = y >> shift;
			for (int i = 0; i < SQR_STEPS; i++) begin
				m    = (m * m) >> 16;
				frac = frac << 1;
				if (m >= (64'd2 << 16)) begin
					frac = frac | 64'd1;
					m    = m >> 1;
				end
			end
			return (shift << 16) | frac;
		endfunction

		function logic [7:0] predict_level(logic [7:0] pixel);
			logic [63:0] ratio;
			logic [63:0] lg;
			logic [63:0] level;
			if (peak_level == 0)
				return '0;
			ratio = (64'(pixel) << 16) / 64'(peak_level);
			lg    = log2_fixed((64'd1 << 16) + ratio);
			level = (64'(contrast) * lg * 64'(LEVEL_MAX)) >> 24;
			if (level >= 64'(LEVELS))
				level = 64'(LEVEL_MAX);
			return level[7:0];
		endfunction

		function void note_beat(logic [1:0] act, logic [7:0] pixel);
			case (act)
				ACT_CLEAR: peak_level = '0;
				ACT_OBSERVE: begin
					if (pixel > peak_level)
						peak_level = pixel;
				end
				ACT_MAP: expected_levels.push_back(predict_level(pixel));
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
			$display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_beat(logic [7:0] got);
			logic [7:0] want;
			if (expected_levels.size() == 0) begin
				report_mismatch("result beat with no map pending", got, 8'd0);
			end else begin
				want = expected_levels.pop_front();
				if (got !== want)
					report_mismatch("mapped_value", got, want);
			end
		endtask

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [11:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;

	remap_tracker tracker = new();
	int           burst_left;
	int           beats_counted;

	log_luminance_remap uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("testbench NOT OK");
		$finish;
	end

	// Hold tready in runs of random length, long open stretches now and then.
	initial begin
		int  run_left;
		bit  ready_mode;
		run_left      = 0;
		ready_mode    = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				ready_mode = !ready_mode;
				if (ready_mode)
					run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 20);
				else
					run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 6);
			end
			m_axis_tready = ready_mode;
			run_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_beat(m_axis_tdata);
	end

	// Called and returns at a falling edge.
	task send_beat(logic [1:0] act, logic [7:0] pixel);
		int gap;
		if (burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = pixel;
		s_axis_tuser  = act;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.note_beat(act, pixel);
		if (act != ACT_UNUSED)
			beats_counted++;
		burst_left--;
		@(negedge clk);
	endtask

	task write_contrast(logic [11:0] gain);
		s_axis_tvalid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = gain;
		@(negedge clk);
		cfg_wr_en        = 1'b0;
		tracker.contrast = gain;
	endtask

	// Mostly clear / observe pass / map pass frames; the rest is noise.
	task run_frames(int target);
		int         stop_at;
		int         n;
		int         top;
		logic [7:0] pass[$];
		stop_at = beats_counted + target;
		while (beats_counted < stop_at) begin
			if ($urandom_range(0, 99) < 85) begin
				top = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 255;
				n   = $urandom_range(1, 16);
				pass.delete();
				if ($urandom_range(0, 9) != 0)
					send_beat(ACT_CLEAR, 8'($urandom_range(0, 255)));
				for (int i = 0; i < n; i++) begin
					pass.push_back(8'($urandom_range(0, top)));
					send_beat(ACT_OBSERVE, pass[i]);
				end
				if ($urandom_range(0, 7) == 0)
					send_beat(ACT_UNUSED, 8'($urandom_range(0, 255)));
				for (int i = 0; i < n; i++)
					send_beat(ACT_MAP, pass[i]);
				if ($urandom_range(0, 3) == 0)
					send_beat(ACT_MAP, 8'($urandom_range(0, 255)));
			end else begin
				send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [11:0] gain;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		burst_left    = 0;
		beats_counted = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// peak still zero after reset
		send_beat(ACT_MAP, 8'd255);
		send_beat(ACT_MAP, 8'd0);
		send_beat(ACT_UNUSED, 8'd200);
		send_beat(ACT_OBSERVE, 8'd0);
		send_beat(ACT_MAP, 8'd0);
		// full-range peak
		send_beat(ACT_OBSERVE, 8'd255);
		send_beat(ACT_OBSERVE, 8'd10);
		send_beat(ACT_MAP, 8'd0);
		send_beat(ACT_MAP, 8'd255);
		send_beat(ACT_MAP, 8'd128);
		send_beat(ACT_MAP, 8'd1);
		// smallest peak, samples from far above it down to zero
		send_beat(ACT_CLEAR, 8'd255);
		send_beat(ACT_OBSERVE, 8'd1);
		send_beat(ACT_MAP, 8'd255);
		send_beat(ACT_MAP, 8'd1);
		send_beat(ACT_MAP, 8'd0);
		// unused action leaves the peak alone
		send_beat(ACT_OBSERVE, 8'd100);
		send_beat(ACT_MAP, 8'd200);
		send_beat(ACT_UNUSED, 8'd255);
		send_beat(ACT_MAP, 8'd100);
		send_beat(ACT_CLEAR, 8'd0);
		send_beat(ACT_MAP, 8'd50);

		for (int set = 0; set < GAIN_SETTINGS; set++) begin
			case (set)
				0: gain = 12'd4095;
				1: gain = 12'd0;
				2: gain = 12'd1;
				3: gain = CONTRAST_RESET;
				default: gain = 12'($urandom_range(0, 4095));
			endcase
			write_contrast(gain);
			run_frames(BEATS_PER_SET);
		end

		s_axis_tvalid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
